// ----- hw/rtl/cap_pkg.sv -----
// Shared types, constants and arithmetic helpers for the comb/allpass reverberator.
// No dependencies; every other file imports this package.
package cap_pkg;

    // Defaults for the top-level parameters
    localparam int COMB_DEPTH_DEF    = 4096;
    localparam int ALLPASS_DEPTH_DEF = 1024;
    localparam int SAMPLE_WIDTH_DEF  = 16;

    // Fixed structure
    localparam int COMB_COUNT    = 4;
    localparam int ALLPASS_COUNT = 2;
    localparam int INT_W         = 24;
    localparam int LEN_W         = 12;
    localparam int BASE_W        = 11;

    // Register port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    typedef logic signed [INT_W-1:0] word_t;
    typedef logic [16:0]             mix_t;
    typedef logic [15:0]             fb_t;
    typedef logic [9:0]              scale_t;
    typedef logic [LEN_W-1:0]        len_t;

    localparam logic [REG_IDX_W-1:0] REG_MIX      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE     = 2'd2;

    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    localparam mix_t   MIX_ONE      = 17'd65536;
    localparam mix_t   MIX_RESET    = 17'd32768;
    localparam fb_t    FB_MAX       = 16'd58982;
    localparam fb_t    FB_RESET     = 16'd45875;
    localparam scale_t SCALE_MIN    = 10'd128;
    localparam scale_t SCALE_MAX    = 10'd512;
    localparam scale_t SCALE_RESET  = 10'd256;

    typedef struct packed {
        mix_t                          mix;
        fb_t                           feedback;
        scale_t                        size_scale;
        logic                          resize;
        len_t [COMB_COUNT-1:0]         comb_len;
        len_t [ALLPASS_COUNT-1:0]      ap_len;
    } cap_cfg_t;

    typedef struct packed {
        logic step;
        logic clear;
    } line_ctl_t;

    function automatic logic [BASE_W-1:0] comb_base(input logic [1:0] idx);
        logic [BASE_W-1:0] b;
        case (idx)
            2'd0:    b = 11'd1116;
            2'd1:    b = 11'd1188;
            2'd2:    b = 11'd1277;
            default: b = 11'd1356;
        endcase
        return b;
    endfunction

    function automatic logic [BASE_W-1:0] ap_base(input logic idx);
        logic [BASE_W-1:0] b;
        case (idx)
            1'b0:    b = 11'd225;
            default: b = 11'd341;
        endcase
        return b;
    endfunction

    // floor(base * scale / 256)
    function automatic len_t scaled_len(input logic [BASE_W-1:0] base, input scale_t s);
        logic [20:0] p;
        p = 21'(base) * 21'(s);
        return len_t'(p >> 8);
    endfunction

    // v / 2^n, rounded to nearest with halves away from zero
    function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                     input int unsigned n);
        logic signed [47:0] adj;
        adj = v + (48'sd1 <<< (n - 1));
        if (v[47])
            adj = adj - 48'sd1;
        return adj >>> n;
    endfunction

    function automatic word_t sat_int(input logic signed [47:0] v);
        word_t r;
        if (v > 48'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -48'sd8388608)
            r = 24'sh800000;
        else
            r = v[INT_W-1:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/comb_allpass_reverb.sv -----
// Top level of the comb/allpass reverberator: input stage, comb and allpass
// arithmetic, delay lines, register file and mix stage. Depends on cap_pkg.
//
//  port group         direction  handshake             payload
//  input items        in         in_valid / in_stall   command, in_sample
//  result items       out        out_valid / out_stall out_sample
//  register port      in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One item per cycle unless stalled; items pass the input stage, mix stage and
// output register. Each delay line has one write and one prefetch read per
// cycle, which sets that rate. Reset, a size write or a clear command zero all
// positions and fill flags; lines read as zero until they wrap, so no sweep.
// out_stall holds the output register; the mix stage and then the input stage
// fill behind it before in_stall rises. A clear command yields no result.
module comb_allpass_reverb #(
    parameter int COMB_DEPTH    = cap_pkg::COMB_DEPTH_DEF,
    parameter int ALLPASS_DEPTH = cap_pkg::ALLPASS_DEPTH_DEF,
    parameter int SAMPLE_WIDTH  = cap_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cap_pkg::PADDR_W-1:0]    paddr,
    input  logic [cap_pkg::PDATA_W-1:0]    pwdata,
    output logic [cap_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import cap_pkg::*;

    cap_cfg_t                       cfg;
    line_ctl_t                      line_ctl;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_cmd_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_x_reg;
    logic                           in_take;
    logic                           s1_fire;
    logic                           s2_free;
    logic                           mix_load;
    word_t                          comb_rd [COMB_COUNT];
    word_t                          comb_wr [COMB_COUNT];
    word_t                          ap_rd [ALLPASS_COUNT];
    word_t                          ap_wr [ALLPASS_COUNT];
    word_t                          wet_chain [ALLPASS_COUNT+1];
    logic signed [40:0]             comb_prod [COMB_COUNT];
    logic signed [47:0]             comb_sum;
    logic signed [47:0]             wet_round;
    logic signed [16:0]             fb_s;

    assign pready = 1'b1;

    cap_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Input stage: the item is applied to the delay lines when it leaves here
    assign s1_fire  = s1_valid_reg && ((s1_cmd_reg == CMD_CLEAR) || s2_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;
    assign mix_load = s1_fire && (s1_cmd_reg == CMD_PROCESS);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_cmd_reg   <= CMD_PROCESS;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_take)
                s1_cmd_reg <= command;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_x_reg <= in_sample;
    end

    always_comb
    begin
        line_ctl.step  = mix_load;
        line_ctl.clear = (s1_fire && (s1_cmd_reg == CMD_CLEAR)) || cfg.resize;
    end

    generate
        for (genvar i = 0; i < COMB_COUNT; i++)
        begin : g_comb
            cap_delay #(
                .DEPTH (COMB_DEPTH)
            ) u_line (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (line_ctl),
                .len     (cfg.comb_len[i]),
                .wr_data (comb_wr[i]),
                .rd_data (comb_rd[i])
            );
        end
        for (genvar i = 0; i < ALLPASS_COUNT; i++)
        begin : g_ap
            cap_delay #(
                .DEPTH (ALLPASS_DEPTH)
            ) u_line (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (line_ctl),
                .len     (cfg.ap_len[i]),
                .wr_data (ap_wr[i]),
                .rd_data (ap_rd[i])
            );
        end
    endgenerate

    // Comb feedback and the averaged comb output
    always_comb
    begin
        fb_s     = $signed({1'b0, cfg.feedback});
        comb_sum = '0;
        for (int i = 0; i < COMB_COUNT; i++)
        begin
            comb_prod[i] = comb_rd[i] * fb_s;
            comb_wr[i]   = sat_int(48'(s1_x_reg) + rnd_shift(48'(comb_prod[i]), 16));
            comb_sum     = comb_sum + 48'(comb_rd[i]);
        end
        wet_round = rnd_shift(comb_sum, 2);
    end

    // Two allpass stages in series
    always_comb
    begin
        wet_chain[0] = wet_round[INT_W-1:0];
        for (int k = 0; k < ALLPASS_COUNT; k++)
        begin
            ap_wr[k]       = sat_int(48'(wet_chain[k]) + rnd_shift(48'(ap_rd[k]), 1));
            wet_chain[k+1] = sat_int(48'(ap_rd[k]) - 48'(wet_chain[k]));
        end
    end

    cap_mix #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (mix_load),
        .x          (s1_x_reg),
        .wet        (wet_chain[ALLPASS_COUNT]),
        .mix        (cfg.mix),
        .free       (s2_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample)
    );

    a_comb_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        line_ctl.clear |=> (comb_rd[0] == '0 && comb_rd[COMB_COUNT-1] == '0))
        else $error("comb line not empty after clear");

    a_ap_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        line_ctl.clear |=> (ap_rd[0] == '0 && ap_rd[ALLPASS_COUNT-1] == '0))
        else $error("allpass line not empty after clear");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (!s2_free && s1_cmd_reg == CMD_PROCESS))
        else $error("input stalled while the mix stage could take the item");

endmodule

// ----- hw/rtl/cap_regs.sv -----
// Register file behind the APB-style port: mix, feedback and size scale, with
// the delay lengths derived on a size write. Depends on cap_pkg.
module cap_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cap_pkg::PADDR_W-1:0] paddr,
    input  logic [cap_pkg::PDATA_W-1:0] pwdata,
    output logic [cap_pkg::PDATA_W-1:0] prdata,
    output cap_pkg::cap_cfg_t           cfg
);
    import cap_pkg::*;

    mix_t                     mix_reg, mix_next;
    fb_t                      fb_reg, fb_next;
    scale_t                   scale_reg, scale_next;
    len_t [COMB_COUNT-1:0]    comb_len_reg, comb_len_next;
    len_t [ALLPASS_COUNT-1:0] ap_len_reg, ap_len_next;
    logic                     wr_en;
    logic                     resize;
    logic [REG_IDX_W-1:0]     reg_idx;
    scale_t                   scale_clamped;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        scale_clamped = pwdata[9:0];
        if (scale_clamped < SCALE_MIN)
            scale_clamped = SCALE_MIN;
        else if (scale_clamped > SCALE_MAX)
            scale_clamped = SCALE_MAX;
    end

    always_comb
    begin
        mix_next      = mix_reg;
        fb_next       = fb_reg;
        scale_next    = scale_reg;
        comb_len_next = comb_len_reg;
        ap_len_next   = ap_len_reg;
        resize        = 1'b0;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIX:
                    mix_next = (pwdata[16:0] > MIX_ONE) ? MIX_ONE : pwdata[16:0];
                REG_FEEDBACK:
                    fb_next = (pwdata[15:0] > FB_MAX) ? FB_MAX : pwdata[15:0];
                REG_SIZE:
                begin
                    scale_next = scale_clamped;
                    resize     = 1'b1;
                    for (int i = 0; i < COMB_COUNT; i++)
                        comb_len_next[i] = scaled_len(comb_base(2'(i)), scale_clamped);
                    for (int i = 0; i < ALLPASS_COUNT; i++)
                        ap_len_next[i] = scaled_len(ap_base(1'(i)), scale_clamped);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_reg   <= MIX_RESET;
            fb_reg    <= FB_RESET;
            scale_reg <= SCALE_RESET;
            for (int i = 0; i < COMB_COUNT; i++)
                comb_len_reg[i] <= len_t'(comb_base(2'(i)));
            for (int i = 0; i < ALLPASS_COUNT; i++)
                ap_len_reg[i] <= len_t'(ap_base(1'(i)));
        end
        else
        begin
            mix_reg      <= mix_next;
            fb_reg       <= fb_next;
            scale_reg    <= scale_next;
            comb_len_reg <= comb_len_next;
            ap_len_reg   <= ap_len_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIX:      prdata = PDATA_W'(mix_reg);
            REG_FEEDBACK: prdata = PDATA_W'(fb_reg);
            REG_SIZE:     prdata = PDATA_W'(scale_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.mix        = mix_reg;
        cfg.feedback   = fb_reg;
        cfg.size_scale = scale_reg;
        cfg.resize     = resize;
        cfg.comb_len   = comb_len_reg;
        cfg.ap_len     = ap_len_reg;
    end

endmodule

// ----- hw/rtl/cap_delay.sv -----
// One circular delay line: memory, position counter and fill flag.
// Depends on cap_pkg. Reads one position ahead so data is ready for the next item.
module cap_delay #(
    parameter int DEPTH = cap_pkg::COMB_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cap_pkg::line_ctl_t ctl,
    input  cap_pkg::len_t      len,
    input  cap_pkg::word_t     wr_data,
    output cap_pkg::word_t     rd_data
);
    import cap_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;

    logic [AW-1:0] pos_reg, pos_next;
    logic          full_reg, full_next;
    logic [CW-1:0] pos_inc;
    word_t         mem [DEPTH];
    word_t         rd_reg;

    // Entries at and beyond the position are unwritten until the line wraps once
    always_comb
    begin
        pos_inc   = CW'(pos_reg) + CW'(1);
        pos_next  = pos_reg;
        full_next = full_reg;
        if (ctl.clear)
        begin
            pos_next  = '0;
            full_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (pos_inc >= CW'(len))
            begin
                pos_next  = '0;
                full_next = 1'b1;
            end
            else
            begin
                pos_next = pos_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            full_reg <= full_next;
        end
    end

    // Write the current position, prefetch the next one
    always_ff @(posedge clk)
    begin
        if (ctl.step)
            mem[pos_reg] <= wr_data;
        rd_reg <= mem[pos_next];
    end

    assign rd_data = full_reg ? rd_reg : '0;

endmodule

// ----- hw/rtl/cap_mix.sv -----
// Dry/wet mix stage and output register with stall handling.
// Depends on cap_pkg.
module cap_mix #(
    parameter int SAMPLE_WIDTH = cap_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  cap_pkg::word_t                 wet,
    input  cap_pkg::mix_t                  mix,
    output logic                           free,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample
);
    import cap_pkg::*;

    localparam logic signed [47:0] OUT_MAX = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
    localparam logic signed [47:0] OUT_MIN = -OUT_MAX - 48'sd1;

    logic                           s2_valid_reg, s2_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] s2_x_reg;
    word_t                          s2_wet_reg;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg, out_sample_next;
    logic                           out_free;
    logic                           s2_move;
    mix_t                           dry_gain;
    logic signed [17:0]             dry_s, wet_s;
    logic signed [47:0]             dry_prod, wet_prod, mixed;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_move  = s2_valid_reg && out_free;
    assign free     = !s2_valid_reg || out_free;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (load)
            s2_valid_next = 1'b1;
        else if (s2_move)
            s2_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        dry_gain = MIX_ONE - mix;
        dry_s    = $signed({1'b0, dry_gain});
        wet_s    = $signed({1'b0, mix});
        dry_prod = s2_x_reg * dry_s;
        wet_prod = s2_wet_reg * wet_s;
        mixed    = rnd_shift(dry_prod + wet_prod, 16);
        if (mixed > OUT_MAX)
            out_sample_next = OUT_MAX[SAMPLE_WIDTH-1:0];
        else if (mixed < OUT_MIN)
            out_sample_next = OUT_MIN[SAMPLE_WIDTH-1:0];
        else
            out_sample_next = mixed[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_x_reg   <= x;
            s2_wet_reg <= wet;
        end
        if (s2_move)
            out_sample_reg <= out_sample_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule
